@@ rtl/itda_pkg.sv @@
// Shared constants and types for the integer to decimal ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package itda_pkg;

  // Field geometry
  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 8;
  localparam int unsigned PosW      = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned StepCntW  = $clog2(ValueW + 1);

  localparam logic [PosW-1:0] TermPos  = PosW'(11);
  localparam logic [PosW-1:0] LastDigitPos = PosW'(10);

  // Character codes
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChTerm  = 8'h00;

  // Status of the iterative BCD converter
  typedef struct packed {
    logic busy;
    logic done;
  } dbl_status_t;

endpackage

`default_nettype wire

@@ rtl/itda_if.sv @@
// Valid/ready channel interfaces for the input value and the output characters.
`timescale 1ns / 1ps
`default_nettype none

interface itda_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [itda_pkg::ValueW-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itda_out_if;
  logic                          valid;
  logic                          ready;
  logic [itda_pkg::CharW-1:0]    char_code;
  logic [itda_pkg::PosW-1:0]     position;
  logic                          last;

  modport source (output valid, output char_code, output position, output last, input ready);
  modport sink   (input valid, input char_code, input position, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/int_to_decimal_ascii.sv @@
// Top level: signed 32-bit integer to right-justified 12-character decimal field.
// Flow: an accepted transaction first runs 32 binary to BCD steps in the shared
// digit-correct-and-shift unit, then the field is handed off to the emitter.
// Throughput: one character per cycle while the sink is ready, 12 per item; input
// ready is high only when idle, so a new item is taken only after the terminator is loaded.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module int_to_decimal_ascii (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  itda_in_if.sink        in_i,
  itda_out_if.source     out_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]                       state_q, state_d;
  logic                             neg_q, neg_d;
  logic [itda_pkg::PosW-1:0]        pos_q, pos_d;
  logic                             ovalid_q, ovalid_d;
  logic [itda_pkg::CharW-1:0]       ochar_q;
  logic [itda_pkg::PosW-1:0]        opos_q;
  logic                             olast_q;

  logic                             in_fire;
  logic                             out_load;
  logic [itda_pkg::ValueW-1:0]      mag;
  itda_pkg::dbl_status_t            dbl_status;
  logic [itda_pkg::BcdW-1:0]        bcd;
  logic [3:0]                       digits [itda_pkg::NumDigits];
  logic [3:0]                       num_digits;
  logic [3:0]                       dig_idx;
  logic [3:0]                       dig_sel;
  logic [itda_pkg::CharW-1:0]       char_nxt;

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;

  // Take the magnitude; the most negative value wraps to its true magnitude
  assign mag = in_i.value[itda_pkg::ValueW-1] ? (~in_i.value + 1'b1) : in_i.value;

  itda_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .mag_i    (mag),
    .status_o (dbl_status),
    .bcd_o    (bcd)
  );

  // Split digits and count significant ones (at least one, for zero)
  always_comb begin
    num_digits = 4'd1;
    for (int i = 0; i < itda_pkg::NumDigits; i++) begin
      digits[i] = bcd[4*i +: 4];
      if (bcd[4*i +: 4] != 4'd0) begin
        num_digits = 4'(i + 1);
      end
    end
  end

  // Pick the character for the current position
  assign dig_idx = itda_pkg::LastDigitPos - pos_q;
  assign dig_sel = (pos_q == '0) ? 4'd0 : dig_idx;

  always_comb begin
    if (pos_q == itda_pkg::TermPos) begin
      char_nxt = itda_pkg::ChTerm;
    end else if (pos_q != '0 && dig_idx < num_digits) begin
      char_nxt = itda_pkg::ChZero + {4'd0, digits[dig_sel]};
    end else if (neg_q && dig_idx == num_digits) begin
      char_nxt = itda_pkg::ChMinus;
    end else begin
      char_nxt = itda_pkg::ChSpace;
    end
  end

  assign out_load = (state_q == StEmit) && (!ovalid_q || out_o.ready);

  // Sequence: idle, convert, emit the field
  always_comb begin
    state_d  = state_q;
    neg_d    = neg_q;
    pos_d    = pos_q;
    ovalid_d = ovalid_q;
    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          neg_d   = in_i.value[itda_pkg::ValueW-1];
          state_d = StConv;
        end
      end
      StConv: begin
        if (dbl_status.done) begin
          pos_d   = '0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_load) begin
          ovalid_d = 1'b1;
          pos_d    = pos_q + itda_pkg::PosW'(1);
          if (pos_q == itda_pkg::TermPos) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      neg_q    <= 1'b0;
      pos_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      neg_q    <= neg_d;
      pos_q    <= pos_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ochar_q <= char_nxt;
      opos_q  <= pos_q;
      olast_q <= (pos_q == itda_pkg::TermPos);
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.char_code = ochar_q;
  assign out_o.position  = opos_q;
  assign out_o.last      = olast_q;

  // An accepted transaction starts the converter
  a_start_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StConv) && dbl_status.busy)
    else $error("conversion did not start after accepted transaction");

  // The converter finishes only while the sequencer waits for it
  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbl_status.done |-> (state_q == StConv))
    else $error("converter done outside conversion state");

  // No emission while the converter is still shifting
  a_emit_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> !dbl_status.busy)
    else $error("emitting while converter busy");

  // The terminator is the only last character and sits at the final position
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last == (out_o.position == itda_pkg::TermPos)))
    else $error("last flag and position disagree");

endmodule

`default_nettype wire

@@ rtl/itda_dabble.sv @@
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle.
`timescale 1ns / 1ps
`default_nettype none

module itda_dabble (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [itda_pkg::ValueW-1:0]   mag_i,
  output      itda_pkg::dbl_status_t         status_o,
  output      logic [itda_pkg::BcdW-1:0]     bcd_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [itda_pkg::StepCntW-1:0]      cnt_q, cnt_d;
  logic [itda_pkg::ValueW-1:0]        sh_q, sh_d;
  logic [itda_pkg::BcdW-1:0]          bcd_q, bcd_d;
  logic [itda_pkg::BcdW-1:0]          bcd_adj;

  // Correct each digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < itda_pkg::NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Sequence the steps: load on start, shift while busy
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = itda_pkg::StepCntW'(itda_pkg::ValueW);
      sh_d   = mag_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[itda_pkg::BcdW-2:0], sh_q[itda_pkg::ValueW-1]};
      sh_d  = {sh_q[itda_pkg::ValueW-2:0], 1'b0};
      cnt_d = cnt_q - itda_pkg::StepCntW'(1);
      if (cnt_q == itda_pkg::StepCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold datapath
  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign bcd_o         = bcd_q;

endmodule

`default_nettype wire
